FILE: rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants for the call-frame instruction encoder.
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_ADJUST = 2'd1;
	localparam logic [1:0] OP_VSAVE  = 2'd2;

	localparam logic [7:0]  CFA_DEF_OFFSET = 8'h0e;
	localparam logic [7:0]  CFA_OFFSET_OP  = 8'h80;
	localparam logic [7:0]  CFA_ADVANCE_OP = 8'h40;
	localparam logic [7:0]  CFA_ADVANCE1   = 8'h02;
	localparam logic [7:0]  CFA_ADVANCE2   = 8'h03;
	localparam logic [7:0]  CFA_ADVANCE4   = 8'h04;
	localparam logic [5:0]  VEC_DWARF_BASE = 6'd17;
	localparam logic [31:0] STACK_OFFSET_RESET = 32'd8;
	localparam logic [31:0] PUSH_SIZE          = 32'd8;
	localparam logic [63:0] REG_MAP_RESET      = 64'hFEDC_BA98_7654_3210;

	typedef struct packed {
		logic [1:0]         operation;
		logic               first;
		logic [31:0]        code_offset;
		logic [3:0]         reg_index;
		logic [31:0]        adjust_amount;
		logic signed [31:0] vector_slot_offset;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       last;
	} out_item_t;

	// One classified event, ready for byte serialization.
	typedef struct packed {
		logic [7:0]  adv_first;
		logic [2:0]  adv_len;
		logic [31:0] delta;
		logic [7:0]  op1;
		logic [7:0]  op2;
		logic        two_ops;
		logic [31:0] value;
	} cmd_t;

endpackage

FILE: rtl/cfa_front.sv
// ----------------------------------------------------------------------------
// cfa_front
// Accepts prologue events, tracks frame state and classifies each event
// into a command for the byte serializer.
// ----------------------------------------------------------------------------
module cfa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [63:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  cfa_pkg::in_item_t in_data,
	input  logic              full,
	output logic              push,
	output cfa_pkg::cmd_t     push_data
);

	logic [63:0] reg_map_q;
	logic [31:0] stack_offset_q;
	logic [31:0] last_code_q;

	logic [31:0] base_so;
	logic [31:0] base_code;
	logic [31:0] delta;
	logic        backward;
	logic [31:0] new_so;
	logic [3:0]  dreg;
	logic        op_ok;
	logic        accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign op_ok    = (in_data.operation == cfa_pkg::OP_PUSH) ||
			  (in_data.operation == cfa_pkg::OP_ADJUST) ||
			  (in_data.operation == cfa_pkg::OP_VSAVE);
	assign push     = accept && op_ok;

	// A new prologue restarts from the reset frame before the event applies.
	assign base_so   = in_data.first ? cfa_pkg::STACK_OFFSET_RESET : stack_offset_q;
	assign base_code = in_data.first ? 32'd0 : last_code_q;
	assign delta     = in_data.code_offset - base_code;
	assign backward  = in_data.code_offset < base_code;
	assign dreg      = reg_map_q[{in_data.reg_index, 2'b00} +: 4];

	always_comb begin
		new_so            = base_so;
		push_data.op1     = cfa_pkg::CFA_DEF_OFFSET;
		push_data.op2     = cfa_pkg::CFA_OFFSET_OP | {4'd0, dreg};
		push_data.two_ops = 1'b0;
		push_data.value   = base_so;
		case (in_data.operation)
			cfa_pkg::OP_PUSH: begin
				new_so            = base_so + cfa_pkg::PUSH_SIZE;
				push_data.two_ops = 1'b1;
				push_data.value   = new_so;
			end
			cfa_pkg::OP_ADJUST: begin
				new_so          = base_so + in_data.adjust_amount;
				push_data.value = new_so;
			end
			default: begin
				push_data.op1   = cfa_pkg::CFA_OFFSET_OP |
						  {2'd0, cfa_pkg::VEC_DWARF_BASE + {2'd0, in_data.reg_index}};
				push_data.value = base_so - $unsigned(in_data.vector_slot_offset);
			end
		endcase

		push_data.delta = delta;
		if (!backward && delta < 32'd64) begin
			push_data.adv_first = cfa_pkg::CFA_ADVANCE_OP | {2'd0, delta[5:0]};
			push_data.adv_len   = 3'd1;
		end else if (!backward && delta < 32'd256) begin
			push_data.adv_first = cfa_pkg::CFA_ADVANCE1;
			push_data.adv_len   = 3'd2;
		end else if (!backward && delta < 32'd65536) begin
			push_data.adv_first = cfa_pkg::CFA_ADVANCE2;
			push_data.adv_len   = 3'd3;
		end else begin
			push_data.adv_first = cfa_pkg::CFA_ADVANCE4;
			push_data.adv_len   = 3'd5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_map_q      <= cfa_pkg::REG_MAP_RESET;
			stack_offset_q <= cfa_pkg::STACK_OFFSET_RESET;
			last_code_q    <= 32'd0;
		end else begin
			if (cfg_we)
				reg_map_q <= cfg_data;
			if (push) begin
				stack_offset_q <= new_so;
				last_code_q    <= in_data.code_offset;
			end
		end
	end

endmodule

FILE: rtl/cfa_queue.sv
// ----------------------------------------------------------------------------
// cfa_queue
// Small command FIFO between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
module cfa_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cfa_pkg::cmd_t push_data,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output cfa_pkg::cmd_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cfa_pkg::cmd_t    entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/cfa_back.sv
// ----------------------------------------------------------------------------
// cfa_back
// Serializes one queued command into call-frame bytes, one beat per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module cfa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cfa_pkg::cmd_t      cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output cfa_pkg::out_item_t out_data
);

	typedef enum logic [1:0] {
		ST_ADV,
		ST_OP,
		ST_ULEB
	} state_t;

	state_t             state_q;
	logic [2:0]         idx_q;
	logic               second_q;
	logic [31:0]        uleb_q;
	logic               out_valid_q;
	cfa_pkg::out_item_t out_data_q;

	logic               advance;
	logic               emit;
	logic [7:0]         byte_n;
	logic               final_n;
	logic [7:0]         delta_byte;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign advance   = !out_valid_q || !out_stall;
	assign emit      = advance && cmd_valid;

	always_comb begin
		case (idx_q)
			3'd1:    delta_byte = cmd.delta[7:0];
			3'd2:    delta_byte = cmd.delta[15:8];
			3'd3:    delta_byte = cmd.delta[23:16];
			default: delta_byte = cmd.delta[31:24];
		endcase
	end

	always_comb begin
		final_n = 1'b0;
		case (state_q)
			ST_ADV:  byte_n = (idx_q == 3'd0) ? cmd.adv_first : delta_byte;
			ST_OP:   byte_n = second_q ? cmd.op2 : cmd.op1;
			ST_ULEB: begin
				byte_n  = {uleb_q[31:7] != '0, uleb_q[6:0]};
				final_n = (uleb_q[31:7] == '0) && !(cmd.two_ops && !second_q);
			end
			default: byte_n = 8'd0;
		endcase
	end

	assign pop = emit && final_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ADV;
			idx_q       <= 3'd0;
			second_q    <= 1'b0;
			uleb_q      <= 32'd0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (advance) begin
				out_valid_q         <= cmd_valid;
				out_data_q.byte_out <= byte_n;
				out_data_q.last     <= final_n;
			end
			if (emit) begin
				case (state_q)
					ST_ADV: begin
						if (idx_q == cmd.adv_len - 3'd1) begin
							idx_q   <= 3'd0;
							state_q <= ST_OP;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
					ST_OP: begin
						uleb_q  <= cmd.value;
						state_q <= ST_ULEB;
					end
					ST_ULEB: begin
						if (uleb_q[31:7] != '0) begin
							uleb_q <= {7'd0, uleb_q[31:7]};
						end else if (cmd.two_ops && !second_q) begin
							// A push repeats the offset for its register save op.
							second_q <= 1'b1;
							state_q  <= ST_OP;
						end else begin
							second_q <= 1'b0;
							state_q  <= ST_ADV;
						end
					end
					default: state_q <= ST_ADV;
				endcase
			end
		end
	end

endmodule

FILE: rtl/cfa_unwind_op_encoder.sv
// The first byte of an event passes through the command queue and then the registered
// output stage before it reaches the output, when the queue is empty and the output is free.
// Throughput: one output beat per cycle while the output is not stalled; push events
// produce the most bytes.
// Events are accepted every cycle while the command queue has room.
// Reset clears the frame state to stack offset 8, last code offset 0,
// and restores the identity register map; the queue starts empty.
// ----------------------------------------------------------------------------
// cfa_unwind_op_encoder
// Turns prologue events into DWARF call-frame instruction bytes.
// ----------------------------------------------------------------------------
module cfa_unwind_op_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  cfa_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output cfa_pkg::out_item_t out_data
);

	logic          full;
	logic          push;
	logic          pop;
	logic          not_empty;
	cfa_pkg::cmd_t push_data;
	cfa_pkg::cmd_t head;

	cfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	cfa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	cfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (not_empty),
		.cmd       (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
